FILE: rtl/icr_pkg.sv
// Shared types, constants and arithmetic helpers for the impulse collision resolve core.
// No dependencies; imported by every module of the block.
package icr_pkg;

  localparam int IN_W  = 296;
  localparam int OUT_W = 264;

  localparam int RCP_STEPS = 33;
  localparam int SHR_STEPS = 17;
  localparam int ST_ISUM   = RCP_STEPS + 1;
  localparam int ST_SCALE  = ST_ISUM + SHR_STEPS + 1;
  localparam int ST_MUL    = ST_SCALE + 1;
  localparam int ST_OUT    = ST_MUL + 1;
  localparam int NSTG      = ST_OUT + 1;

  localparam logic [30:0] SLOP_Q    = 31'd655;
  localparam logic [15:0] PERCENT_Q = 16'd58982;
  localparam logic [17:0] FRAC_ONE  = 18'd65536;

  typedef struct packed {
    logic [17:0] nx;
    logic [17:0] ny;
    logic [30:0] p;
    logic [30:0] ma;
    logic [30:0] mb;
    logic [16:0] e;
    logic [1:0]  sf;
    logic [31:0] vax;
    logic [31:0] vay;
    logic [31:0] vbx;
    logic [31:0] vby;
    logic [32:0] dx;
    logic [32:0] dy;
    logic [50:0] mx;
    logic [50:0] my;
    logic [51:0] dot;
    logic [30:0] pp;
    logic [36:0] jq;
    logic [31:0] rema;
    logic [31:0] remb;
    logic [32:0] qa;
    logic [32:0] qb;
    logic [32:0] inva;
    logic [32:0] invb;
    logic [33:0] isum;
    logic [34:0] shra;
    logic [34:0] shrb;
    logic [16:0] fa;
    logic [16:0] fb;
    logic        apply;
    logic [36:0] ka;
    logic [36:0] kb;
    logic [30:0] ca;
    logic [30:0] cb;
    logic [37:0] tkax;
    logic [37:0] tkay;
    logic [37:0] tkbx;
    logic [37:0] tkby;
    logic [32:0] tcax;
    logic [32:0] tcay;
    logic [32:0] tcbx;
    logic [32:0] tcby;
    logic        resolved;
    logic [31:0] nvax;
    logic [31:0] nvay;
    logic [31:0] nvbx;
    logic [31:0] nvby;
    logic [31:0] shax;
    logic [31:0] shay;
    logic [31:0] shbx;
    logic [31:0] shby;
  } item_t;

  typedef struct packed {
    logic adv;
    logic skid_load;
    logic skid_vld;
  } ctl_t;

  function automatic logic [31:0] sat32(input logic signed [40:0] v);
    logic [31:0] r;
    if (v > 41'sd2147483647) r = 32'h7fff_ffff;
    else if (v < -41'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [31:0] add_sat(input logic [31:0] base, input logic [37:0] mag,
                                          input logic neg);
    logic signed [40:0] b;
    logic signed [40:0] m;
    logic signed [40:0] s;
    b = 41'($signed(base));
    m = $signed({3'b0, mag});
    s = neg ? b - m : b + m;
    return sat32(s);
  endfunction

endpackage

FILE: rtl/icr_ctl.sv
// Stage valid bits, pipeline advance and output skid control.
// Depends on icr_pkg.
module icr_ctl import icr_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            out_ready,
  output logic [NSTG-1:0] vld,
  output ctl_t            ctl
);

  logic skid_vld;
  logic skid_vld_next;

  always_comb begin
    ctl.adv       = !skid_vld;
    ctl.skid_load = !skid_vld && vld[NSTG-1] && !out_ready;
    ctl.skid_vld  = skid_vld;
    skid_vld_next = skid_vld ? !out_ready : ctl.skid_load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      skid_vld <= 1'b0;
    end else begin
      skid_vld <= skid_vld_next;
      if (ctl.adv) vld <= {vld[NSTG-2:0], in_valid};
    end
  end

endmodule

FILE: rtl/impulse_collision_resolve_core.sv
// Impulse collision resolve core: one 2D contact pair per cycle in, one result per cycle out,
// while the output skid is empty. The pipeline holds two per-stage restoring dividers (33
// reciprocal steps for the inverse masses, 17 steps for the mass shares), with multiplies
// before and after; a one-entry output skid holds an untaken result, stalling input while full.
// Depends on icr_pkg and icr_ctl.
module impulse_collision_resolve_core import icr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // normal_x, normal_y, penetration, mass_a, mass_b, restitution_a, restitution_b,
  // static_flags, velocity_a_x, velocity_a_y, velocity_b_x, velocity_b_y, zero pad
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // resolved, new_velocity_a_x, new_velocity_a_y, new_velocity_b_x, new_velocity_b_y,
  // shift_a_x, shift_a_y, shift_b_x, shift_b_y, zero pad
  output logic [OUT_W-1:0] m_tdata
);

  logic [NSTG-1:0] vld;
  ctl_t            ctl;
  item_t           st [NSTG];
  item_t           cap;
  logic [OUT_W-1:0] skid;
  logic [OUT_W-1:0] last_data;

  icr_ctl u_ctl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .out_ready (m_tready),
    .vld       (vld),
    .ctl       (ctl)
  );

  assign s_tready = ctl.adv;

  always_comb begin
    cap      = '0;
    cap.nx   = s_tdata[17:0];
    cap.ny   = s_tdata[35:18];
    cap.ma   = s_tdata[97:67];
    cap.mb   = s_tdata[128:98];
    cap.e    = (s_tdata[145:129] < s_tdata[162:146]) ? s_tdata[145:129] : s_tdata[162:146];
    cap.sf   = s_tdata[164:163];
    cap.vax  = s_tdata[196:165];
    cap.vay  = s_tdata[228:197];
    cap.vbx  = s_tdata[260:229];
    cap.vby  = s_tdata[292:261];
    cap.p    = (s_tdata[66:36] > SLOP_Q) ? s_tdata[66:36] - SLOP_Q : '0;
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) st[0] <= cap;
  end

  for (genvar k = 1; k < NSTG; k++) begin : g_stg
    item_t       it;
    item_t       nxt;
    logic [32:0] rsa;
    logic [32:0] rsb;
    logic [35:0] ssa;
    logic [35:0] ssb;
    logic [17:0] anx;
    logic [17:0] any;
    logic [17:0] one_e;
    logic        add_a;
    logic        add_b;

    always_comb begin
      it    = st[k-1];
      nxt   = it;
      rsa   = {it.rema, (k == 1)};
      rsb   = {it.remb, (k == 1)};
      ssa   = {it.shra, (k == ST_ISUM + 1) ? it.inva[0] : 1'b0};
      ssb   = {it.shrb, (k == ST_ISUM + 1) ? it.invb[0] : 1'b0};
      anx   = it.nx[17] ? 18'(-it.nx) : it.nx;
      any   = it.ny[17] ? 18'(-it.ny) : it.ny;
      one_e = FRAC_ONE + 18'(it.e);
      add_a = it.apply && !it.sf[0];
      add_b = it.apply && !it.sf[1];

      if (k <= RCP_STEPS) begin
        if (rsa >= {2'b0, it.ma}) begin
          nxt.rema = 32'(rsa - {2'b0, it.ma});
          nxt.qa   = {it.qa[31:0], 1'b1};
        end else begin
          nxt.rema = rsa[31:0];
          nxt.qa   = {it.qa[31:0], 1'b0};
        end
        if (rsb >= {2'b0, it.mb}) begin
          nxt.remb = 32'(rsb - {2'b0, it.mb});
          nxt.qb   = {it.qb[31:0], 1'b1};
        end else begin
          nxt.remb = rsb[31:0];
          nxt.qb   = {it.qb[31:0], 1'b0};
        end
      end

      if (k == 1) begin
        nxt.dx = 33'($signed(it.vbx)) - 33'($signed(it.vax));
        nxt.dy = 33'($signed(it.vby)) - 33'($signed(it.vay));
        nxt.pp = 31'((48'(it.p) * 48'(PERCENT_Q)) >> 16);
      end
      if (k == 2) begin
        nxt.mx = 51'($signed(it.dx)) * 51'($signed(it.nx));
        nxt.my = 51'($signed(it.dy)) * 51'($signed(it.ny));
      end
      if (k == 3) begin
        nxt.dot = 52'($signed(it.mx)) + 52'($signed(it.my));
      end
      if (k == 4) begin
        nxt.jq = 37'((54'(one_e) * 54'(it.dot[51:16])) >> 16);
      end

      if (k == ST_ISUM) begin
        nxt.inva = (it.ma == '0) ? '0 : it.qa;
        nxt.invb = (it.mb == '0) ? '0 : it.qb;
        nxt.isum = 34'(nxt.inva) + 34'(nxt.invb);
        nxt.shra = 35'(nxt.inva[32:1]);
        nxt.shrb = 35'(nxt.invb[32:1]);
      end

      if (k > ST_ISUM && k < ST_SCALE) begin
        if (ssa >= {2'b0, it.isum}) begin
          nxt.shra = 35'(ssa - {2'b0, it.isum});
          nxt.fa   = {it.fa[15:0], 1'b1};
        end else begin
          nxt.shra = ssa[34:0];
          nxt.fa   = {it.fa[15:0], 1'b0};
        end
        if (ssb >= {2'b0, it.isum}) begin
          nxt.shrb = 35'(ssb - {2'b0, it.isum});
          nxt.fb   = {it.fb[15:0], 1'b1};
        end else begin
          nxt.shrb = ssb[34:0];
          nxt.fb   = {it.fb[15:0], 1'b0};
        end
      end

      if (k == ST_SCALE) begin
        nxt.apply = !it.dot[51] && (it.isum != '0);
        nxt.ka    = 37'((54'(it.jq) * 54'(it.fa)) >> 16);
        nxt.kb    = 37'((54'(it.jq) * 54'(it.fb)) >> 16);
        nxt.ca    = 31'((48'(it.pp) * 48'(it.fa)) >> 16);
        nxt.cb    = 31'((48'(it.pp) * 48'(it.fb)) >> 16);
      end

      if (k == ST_MUL) begin
        nxt.tkax = 38'((55'(it.ka) * 55'(anx)) >> 16);
        nxt.tkay = 38'((55'(it.ka) * 55'(any)) >> 16);
        nxt.tkbx = 38'((55'(it.kb) * 55'(anx)) >> 16);
        nxt.tkby = 38'((55'(it.kb) * 55'(any)) >> 16);
        nxt.tcax = 33'((49'(it.ca) * 49'(anx)) >> 16);
        nxt.tcay = 33'((49'(it.ca) * 49'(any)) >> 16);
        nxt.tcbx = 33'((49'(it.cb) * 49'(anx)) >> 16);
        nxt.tcby = 33'((49'(it.cb) * 49'(any)) >> 16);
      end

      if (k == ST_OUT) begin
        nxt.resolved = it.apply;
        nxt.nvax = add_a ? add_sat(it.vax, it.tkax, it.nx[17]) : it.vax;
        nxt.nvay = add_a ? add_sat(it.vay, it.tkay, it.ny[17]) : it.vay;
        nxt.nvbx = add_b ? add_sat(it.vbx, it.tkbx, !it.nx[17]) : it.vbx;
        nxt.nvby = add_b ? add_sat(it.vby, it.tkby, !it.ny[17]) : it.vby;
        nxt.shax = add_a ? add_sat('0, {5'b0, it.tcax}, it.nx[17]) : '0;
        nxt.shay = add_a ? add_sat('0, {5'b0, it.tcay}, it.ny[17]) : '0;
        nxt.shbx = add_b ? add_sat('0, {5'b0, it.tcbx}, !it.nx[17]) : '0;
        nxt.shby = add_b ? add_sat('0, {5'b0, it.tcby}, !it.ny[17]) : '0;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.adv) st[k] <= nxt;
    end
  end

  assign last_data = {7'b0, st[NSTG-1].shby, st[NSTG-1].shbx, st[NSTG-1].shay,
                      st[NSTG-1].shax, st[NSTG-1].nvby, st[NSTG-1].nvbx,
                      st[NSTG-1].nvay, st[NSTG-1].nvax, st[NSTG-1].resolved};

  always_ff @(posedge clk) begin
    if (ctl.skid_load) skid <= last_data;
  end

  assign m_tvalid = ctl.skid_vld || vld[NSTG-1];
  assign m_tdata  = ctl.skid_vld ? skid : last_data;

endmodule

FILE: rtl/icr_chk.sv
// Port-level checks for the impulse collision resolve core, bound to the top level.
// Depends on icr_pkg.
module icr_chk import icr_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  a_rst_empty: assert property (@(posedge clk) !rst && $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output item dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("output item changed while stalled");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_W-1:257] == '0)
    else $error("output pad bits not zero");

  a_no_shift: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[256:129] == '0)
    else $error("shift on an unresolved pair");

endmodule

bind impulse_collision_resolve_core icr_chk u_icr_chk (.*);

FILE: tb/impulse_collision_resolve_checker.sv
// Scoreboard for the impulse collision resolve core: predicts each contact result and compares it.
// Watches both stream channels of the core; depends on icr_pkg for the bus widths.
module impulse_collision_resolve_checker import icr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [OUT_W-1:0] m_tdata,
  output int               mismatches,
  output int               outstanding
);

  logic [256:0] expected_results[$];
  string lane_name[8] = '{"new_velocity_a_x", "new_velocity_a_y", "new_velocity_b_x",
                          "new_velocity_b_y", "shift_a_x", "shift_a_y", "shift_b_x",
                          "shift_b_y"};

  function automatic longint scaled(input logic [63:0] mag, input longint n);
    logic [63:0] an;
    longint r;
    an = (n < 0) ? 64'(-n) : 64'(n);
    r = longint'((mag * an) >> 16);
    return (n < 0) ? -r : r;
  endfunction

  function automatic logic [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [256:0] resolve_contact(input logic [IN_W-1:0] d);
    longint nx, ny, vax, vay, vbx, vby, dot;
    longint nvax, nvay, nvbx, nvby, shax, shay, shbx, shby;
    logic [63:0] pen, ma, mb, ra, rb, inva, invb, isum, d16, e, jq, fa, fb, ka, kb;
    logic [63:0] p, pp, ca, cb;
    logic [1:0] sf;
    logic res;
    nx = longint'($signed(d[17:0]));
    ny = longint'($signed(d[35:18]));
    pen = 64'(d[66:36]);
    ma = 64'(d[97:67]);
    mb = 64'(d[128:98]);
    ra = 64'(d[145:129]);
    rb = 64'(d[162:146]);
    sf = d[164:163];
    vax = longint'($signed(d[196:165]));
    vay = longint'($signed(d[228:197]));
    vbx = longint'($signed(d[260:229]));
    vby = longint'($signed(d[292:261]));
    nvax = vax; nvay = vay; nvbx = vbx; nvby = vby;
    shax = 0; shay = 0; shbx = 0; shby = 0;
    res = 1'b0;
    inva = (ma == 0) ? 64'd0 : 64'h1_0000_0000 / ma;
    invb = (mb == 0) ? 64'd0 : 64'h1_0000_0000 / mb;
    isum = inva + invb;
    dot = (vbx - vax) * nx + (vby - vay) * ny;
    if (dot >= 0 && isum != 0) begin
      d16 = 64'(dot) >> 16;
      e = (ra < rb) ? ra : rb;
      jq = ((64'd65536 + e) * d16) >> 16;
      fa = (inva << 16) / isum;
      fb = (invb << 16) / isum;
      ka = (jq * fa) >> 16;
      kb = (jq * fb) >> 16;
      p = (pen > 64'd655) ? pen - 64'd655 : 64'd0;
      pp = (p * 64'd58982) >> 16;
      ca = (pp * fa) >> 16;
      cb = (pp * fb) >> 16;
      res = 1'b1;
      if (!sf[0]) begin
        nvax = vax + scaled(ka, nx);
        nvay = vay + scaled(ka, ny);
        shax = scaled(ca, nx);
        shay = scaled(ca, ny);
      end
      if (!sf[1]) begin
        nvbx = vbx - scaled(kb, nx);
        nvby = vby - scaled(kb, ny);
        shbx = -scaled(cb, nx);
        shby = -scaled(cb, ny);
      end
    end
    return {clamp32(shby), clamp32(shbx), clamp32(shay), clamp32(shax),
            clamp32(nvby), clamp32(nvbx), clamp32(nvay), clamp32(nvax), res};
  endfunction

  assign outstanding = expected_results.size();

  initial mismatches = 0;

  always @(posedge clk) begin
    logic [256:0] want;
    if (!rst) begin
      if (s_tvalid && s_tready)
        expected_results = {expected_results, resolve_contact(s_tdata)};
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $error("result item with no expected result pending");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (want[0] !== m_tdata[0]) begin
            $error("resolved: expected %0d, actual %0d", want[0], m_tdata[0]);
            mismatches++;
          end
          for (int i = 0; i < 8; i++) begin
            if (want[1+32*i +: 32] !== m_tdata[1+32*i +: 32]) begin
              $error("%s: expected %0d, actual %0d", lane_name[i],
                     $signed(want[1+32*i +: 32]), $signed(m_tdata[1+32*i +: 32]));
              mismatches++;
            end
          end
        end
      end
    end
  end

endmodule

FILE: tb/impulse_collision_resolve_core_tb.sv
// Testbench top for the impulse collision resolve core: drives contact pairs and gives the verdict.
// Depends on icr_pkg, the core and impulse_collision_resolve_checker.
module impulse_collision_resolve_core_tb import icr_pkg::*;;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 120;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata;
  logic             m_tvalid;
  logic             m_tready;
  logic [OUT_W-1:0] m_tdata;
  int               mismatches;
  int               outstanding;
  int               cycles;
  int               stall_left;
  logic             gaps_on;

  impulse_collision_resolve_core u_dut (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  impulse_collision_resolve_checker u_checker (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [IN_W-1:0] pack_pair(
    input logic [17:0] nx, input logic [17:0] ny, input logic [30:0] pen,
    input logic [30:0] ma, input logic [30:0] mb, input logic [16:0] ra,
    input logic [16:0] rb, input logic [1:0] sf, input logic [31:0] vax,
    input logic [31:0] vay, input logic [31:0] vbx, input logic [31:0] vby);
    return {3'b0, vby, vbx, vay, vax, sf, rb, ra, mb, ma, pen, ny, nx};
  endfunction

  function automatic logic [17:0] rand_normal();
    if ($urandom_range(0, 9) < 7) return 18'($signed($urandom_range(0, 131072)) - 65536);
    return 18'($urandom);
  endfunction

  function automatic logic [30:0] rand_mass();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 31'd0;
    if (r < 6) return 31'($urandom_range(1, 262144));
    return 31'($urandom);
  endfunction

  function automatic logic [31:0] rand_vel();
    if ($urandom_range(0, 1)) return 32'($signed($urandom_range(0, 2097152)) - 1048576);
    return $urandom;
  endfunction

  function automatic logic [IN_W-1:0] rand_pair();
    logic [17:0] nx, ny;
    logic [31:0] vax, vay, vbx, vby, t;
    logic [30:0] pen;
    logic [16:0] ra, rb;
    longint dt;
    nx = rand_normal();
    ny = rand_normal();
    vax = rand_vel(); vay = rand_vel(); vbx = rand_vel(); vby = rand_vel();
    pen = $urandom_range(0, 1) ? 31'($urandom_range(0, 2000)) : 31'($urandom);
    ra = ($urandom_range(0, 4) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
    rb = ($urandom_range(0, 4) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
    dt = (longint'($signed(vbx)) - longint'($signed(vax))) * longint'($signed(nx)) +
         (longint'($signed(vby)) - longint'($signed(vay))) * longint'($signed(ny));
    if (dt < 0 && $urandom_range(0, 9) < 8) begin
      t = vax; vax = vbx; vbx = t;
      t = vay; vay = vby; vby = t;
    end
    return pack_pair(nx, ny, pen, rand_mass(), rand_mass(), ra, rb, 2'($urandom),
                     vax, vay, vbx, vby);
  endfunction

  task automatic send_pair(input logic [IN_W-1:0] item);
    int g;
    @(negedge clk);
    s_tdata = item;
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    g = gap_len();
    if (g > 0) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  always @(negedge clk) begin
    int r;
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_tready = 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (gaps_on && r < 15) begin
        stall_left = (r < 3) ? $urandom_range(10, 60) : $urandom_range(0, 3);
        m_tready = 1'b0;
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    cycles = 0;
    stall_left = 0;
    gaps_on = 1'b0;
    m_tready = 1'b0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // zero everything, then a separating pair
    send_pair('0);
    send_pair(pack_pair(18'h10000, 18'h0, 31'd65536, 31'd65536, 31'd65536, 17'd32768,
                        17'd65536, 2'b00, 32'h0001_0000, 32'h0, 32'hffff_0000, 32'h0));
    // head-on approach
    send_pair(pack_pair(18'h10000, 18'h0, 31'd65536, 31'd65536, 31'd65536, 17'd32768,
                        17'd32768, 2'b00, 32'hffff_0000, 32'h0, 32'h0001_0000, 32'h0));
    // zero approach speed with depth
    send_pair(pack_pair(18'h0, 18'h10000, 31'd200000, 31'd131072, 31'd65536, 17'd0,
                        17'd0, 2'b00, 32'h0002_0000, 32'h0, 32'h0002_0000, 32'h0));
    // both masses infinite
    send_pair(pack_pair(18'h10000, 18'h0, 31'd65536, 31'd0, 31'd0, 17'd65536, 17'd65536,
                        2'b00, 32'h0001_0000, 32'h0, 32'hffff_0000, 32'h0));
    // static bodies
    for (int s = 1; s < 4; s++)
      send_pair(pack_pair(18'h3_0000, 18'h10000, 31'd100000, 31'd65536, 31'd0, 17'd10000,
                          17'd20000, 2'(s), 32'h0003_0000, 32'h0001_0000,
                          32'hfffd_0000, 32'h0));
    // slop edge
    send_pair(pack_pair(18'h10000, 18'h0, 31'd655, 31'd65536, 31'd65536, 17'd0, 17'd0,
                        2'b00, 32'h0001_0000, 32'h0, 32'h0, 32'h0));
    send_pair(pack_pair(18'h10000, 18'h0, 31'd656, 31'd1, 31'd65536, 17'd0, 17'd0,
                        2'b00, 32'h0001_0000, 32'h0, 32'h0, 32'h0));
    // saturation at both extremes
    send_pair(pack_pair(18'h2_0000, 18'h2_0000, 31'h7fff_ffff, 31'd1, 31'd1, 17'h1ffff,
                        17'h1ffff, 2'b00, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                        32'h8000_0000));
    send_pair(pack_pair(18'h1_ffff, 18'h1_ffff, 31'h7fff_ffff, 31'h7fff_ffff, 31'd1,
                        17'd65536, 17'd65536, 2'b00, 32'h8000_0000, 32'h8000_0000,
                        32'h7fff_ffff, 32'h7fff_ffff));
    send_pair(pack_pair(18'h1_0000, 18'h3_0000, 31'h7fff_ffff, 31'd1, 31'h7fff_ffff,
                        17'd0, 17'h1ffff, 2'b00, 32'h8000_0000, 32'h7fff_ffff,
                        32'h7fff_ffff, 32'h8000_0000));
    // unequal masses, fractional normal
    send_pair(pack_pair(18'hb505, 18'hb505, 31'd3000, 31'd32768, 31'd262144, 17'd45000,
                        17'd20000, 2'b00, 32'h0, 32'h0, 32'hfff0_0000, 32'hfff0_0000));

    // hold off until everything has drained
    @(negedge clk);
    s_tvalid = 1'b0;
    while (outstanding != 0) @(posedge clk);

    gaps_on = 1'b1;
    for (int i = 0; i < 450; i++) begin
      if (i == 150) gaps_on = 1'b0;
      if (i == 220) gaps_on = 1'b1;
      send_pair(rand_pair());
    end
    @(negedge clk);
    s_tvalid = 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
